// ----- rtl/gw5_pkg.sv -----
// gw5_pkg: shared widths, kernel table and queue word type for the 5x5 gaussian window
// no dependencies; compiled first

package gw5_pkg;

   // window geometry
   localparam int WIN    = 5;
   localparam int GREY_W = 10;
   localparam int IDX_W  = 3;

   // weighted sum and divide by 819 via reciprocal
   localparam int SUM_W       = 18;
   localparam int CLS_W       = 13;
   localparam int DIVISOR     = 819;
   localparam int RECIP_SHIFT = 28;
   localparam int RECIP_W     = 19;
   localparam int PROD_W      = SUM_W + RECIP_W;
   localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / DIVISOR);

   // default depth of the queue between front and back
   localparam int DEF_QUEUE_DEPTH = 4;

   // gaussian kernel, sum 273
   localparam int KERNEL [WIN][WIN] = '{
      '{1,  4,  7,  4, 1},
      '{4, 16, 26, 16, 4},
      '{7, 26, 41, 26, 7},
      '{4, 16, 26, 16, 4},
      '{1,  4,  7,  4, 1}
   };

   typedef logic [GREY_W-1:0] grey_type;
   typedef logic [IDX_W-1:0]  idx_type;

   localparam idx_type LAST_IDX = idx_type'(WIN - 1);

   // one classified pixel word: where it lands and what it triggers
   typedef struct packed {
      grey_type grey;
      idx_type  row;
      idx_type  col;
      logic     shift;
      logic     last;
   } entry_type;

endpackage

// ----- rtl/gw5_if.sv -----
// gw5_req_if, gw5_rsp_if: valid/ready channels for pixel words and filtered bytes
// no dependencies

interface gw5_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic       row_start;

   modport source (output valid, red, green, blue, row_start, input ready);
   modport sink   (input valid, red, green, blue, row_start, output ready);
endinterface

interface gw5_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] filtered;

   modport source (output valid, filtered, input ready);
   modport sink   (input valid, filtered, output ready);
endinterface

// ----- rtl/gw5_front.sv -----
// gw5_front: takes pixel words, forms grey values and tags each with its window slot
// depends on gw5_pkg and gw5_req_if

module gw5_front import gw5_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   gw5_req_if.sink     req_chan,
   output logic        push_valid,
   output entry_type   push_entry,
   input  logic        push_ready
);

   idx_type row_ff, row_in;
   idx_type col_ff, col_in;
   logic    mode_ff, mode_in;
   logic    first;
   logic    mode;
   logic    last;
   logic    accept;

   // handshake straight through to the queue
   assign req_chan.ready = push_ready;
   assign push_valid     = req_chan.valid;
   assign accept         = req_chan.valid && push_ready;

   // group start and latched mode
   assign first = (row_ff == '0) && (col_ff == '0);
   assign mode  = first ? req_chan.row_start : mode_ff;
   assign last  = (row_ff == LAST_IDX) && (!mode || (col_ff == LAST_IDX));

   // classify the word
   always_comb begin
      push_entry.grey  = GREY_W'(req_chan.red) + GREY_W'(req_chan.green)
                       + GREY_W'(req_chan.blue);
      push_entry.row   = row_ff;
      push_entry.col   = mode ? col_ff : LAST_IDX;
      push_entry.shift = first && !mode;
      push_entry.last  = last;
   end

   // position within group
   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      mode_in = mode_ff;
      if (accept) begin
         mode_in = mode;
         if (last) begin
            row_in = '0;
            col_in = '0;
         end else if (row_ff == LAST_IDX) begin
            row_in = '0;
            col_in = col_ff + idx_type'(1);
         end else begin
            row_in = row_ff + idx_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         mode_ff <= 1'b0;
      end else begin
         row_ff  <= row_in;
         col_ff  <= col_in;
         mode_ff <= mode_in;
      end
   end

   // position counters stay inside the window
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      row_ff <= LAST_IDX) else $error("row position out of range");
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= LAST_IDX) else $error("column position out of range");
   // a shift group never advances the column
   a_shift_col: assert property (@(posedge clock) disable iff (reset)
      !mode_ff && !first |-> col_ff == '0) else $error("shift group moved column");

endmodule

// ----- rtl/gw5_queue.sv -----
// gw5_queue: short ring buffer of classified words between front and back
// depends on gw5_pkg

module gw5_queue import gw5_pkg::*; #(
   parameter int DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   input  entry_type push_entry,
   output logic      push_ready,
   output logic      pop_valid,
   output entry_type pop_entry,
   input  logic      pop_ready
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type          mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push;
   logic               pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_entry  = mem_ff[rd_ptr_ff];

   // pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH)) else $error("queue overfilled");
   // pointers meet when the queue is empty or full
   a_ptr_level: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == CNT_W'(DEPTH)) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with level");
   a_level_step: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("queue level did not follow push");

endmodule

// ----- rtl/gw5_back.sv -----
// gw5_back: applies words to the window, then weighted sum, divide by 819, output register
// depends on gw5_pkg and gw5_rsp_if

module gw5_back import gw5_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      pop_valid,
   input  entry_type pop_entry,
   output logic      pop_ready,
   gw5_rsp_if.source rsp_chan
);

   grey_type            win_ff [WIN][WIN];
   grey_type            win_in [WIN][WIN];
   logic                en;
   logic                pop;
   logic                done_ff, v1_ff, v2_ff, v3_ff, rsp_valid_ff;
   logic [CLS_W-1:0]    c1_ff, c4_ff, c7_ff, c16_ff, c26_ff, c41_ff;
   logic [CLS_W-1:0]    c1_in, c4_in, c7_in, c16_in, c26_in, c41_in;
   logic [SUM_W-1:0]    wsum_ff, wsum_in;
   logic [SUM_W-1:0]    x_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [QUOT_W-1:0]   q_est;
   logic [QUOT_W-1:0]   q_corr;
   logic [SUM_W-1:0]    rem;
   logic [7:0]          q_ff;

   // whole back end holds while a result waits
   assign en        = !rsp_valid_ff || rsp_chan.ready;
   assign pop_ready = en;
   assign pop       = pop_valid && en;

   // window update: optional column shift, then write one slot
   always_comb begin
      win_in = win_ff;
      if (pop) begin
         if (pop_entry.shift) begin
            for (int r = 0; r < WIN; r++) begin
               for (int c = 0; c < WIN - 1; c++) begin
                  win_in[r][c] = win_ff[r][c + 1];
               end
            end
         end
         win_in[pop_entry.row][pop_entry.col] = pop_entry.grey;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '{default: '0};
      end else begin
         win_ff <= win_in;
      end
   end

   // stage 1: sums per kernel weight
   always_comb begin
      c1_in  = '0;
      c4_in  = '0;
      c7_in  = '0;
      c16_in = '0;
      c26_in = '0;
      c41_in = '0;
      for (int r = 0; r < WIN; r++) begin
         for (int c = 0; c < WIN; c++) begin
            case (KERNEL[r][c])
               1:       c1_in  = c1_in  + CLS_W'(win_ff[r][c]);
               4:       c4_in  = c4_in  + CLS_W'(win_ff[r][c]);
               7:       c7_in  = c7_in  + CLS_W'(win_ff[r][c]);
               16:      c16_in = c16_in + CLS_W'(win_ff[r][c]);
               26:      c26_in = c26_in + CLS_W'(win_ff[r][c]);
               default: c41_in = c41_in + CLS_W'(win_ff[r][c]);
            endcase
         end
      end
   end

   // stage 2: constant weights
   assign wsum_in = SUM_W'(c1_ff) + SUM_W'(c4_ff) * SUM_W'(4) + SUM_W'(c7_ff) * SUM_W'(7)
                  + SUM_W'(c16_ff) * SUM_W'(16) + SUM_W'(c26_ff) * SUM_W'(26)
                  + SUM_W'(c41_ff) * SUM_W'(41);

   // stage 4: reciprocal estimate and one correction step
   assign q_est  = prod_ff[PROD_W-1:RECIP_SHIFT];
   assign rem    = x_ff - SUM_W'(q_est) * SUM_W'(DIVISOR);
   assign q_corr = (rem >= SUM_W'(DIVISOR)) ? q_est + QUOT_W'(1) : q_est;

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff      <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         done_ff      <= pop && pop_entry.last;
         v1_ff        <= done_ff;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         rsp_valid_ff <= v3_ff;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (en) begin
         c1_ff   <= c1_in;
         c4_ff   <= c4_in;
         c7_ff   <= c7_in;
         c16_ff  <= c16_in;
         c26_ff  <= c26_in;
         c41_ff  <= c41_in;
         wsum_ff <= wsum_in;
         prod_ff <= PROD_W'(wsum_ff) * PROD_W'(RECIP);
         x_ff    <= wsum_ff;
         q_ff    <= q_corr[7:0];
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.filtered = q_ff;

   // a shift word always lands at the top of the newest column
   a_shift_slot: assert property (@(posedge clock) disable iff (reset)
      pop && pop_entry.shift |-> pop_entry.col == LAST_IDX && pop_entry.row == '0)
      else $error("shift word targets wrong slot");
   // reciprocal estimate is off by at most one
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> rem < SUM_W'(2 * DIVISOR)) else $error("quotient estimate too low");
   a_quot_byte: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> q_corr[QUOT_W-1:8] == '0) else $error("filtered value exceeds a byte");

endmodule

// ----- rtl/gaussian_5x5_sliding_window_filter_core.sv -----
// gaussian_5x5_sliding_window_filter_core: top level, front, queue and back joined
// depends on gw5_pkg, gw5_if, gw5_front, gw5_queue, gw5_back
//
//   channel   direction   moves                                   word
//   req_chan  in          red, green, blue, row_start             one pixel
//   rsp_chan  out         filtered                                one byte per group
//
// one pixel word accepted per cycle while the queue has room
// the result turns valid once the group's last word has passed each back stage in turn
// (window write, class sums, weighting, reciprocal multiply, correction); queued words and a stalled result delay it
// the window is cleared by reset; reset is synchronous, active high
// a stalled result freezes the back end; the front keeps taking words until the queue fills

module gaussian_5x5_sliding_window_filter_core import gw5_pkg::*; #(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
   input logic       clock,
   input logic       reset,
   gw5_req_if.sink   req_chan,
   gw5_rsp_if.source rsp_chan
);

   logic      push_valid;
   logic      push_ready;
   entry_type push_entry;
   logic      pop_valid;
   logic      pop_ready;
   entry_type pop_entry;

   gw5_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready)
   );

   gw5_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop_ready  (pop_ready)
   );

   gw5_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_entry (pop_entry),
      .pop_ready (pop_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule
